// ===== sv/cpl_pkg.sv =====
// Shared types and constants for the closest-approach line pipeline.
`default_nettype none

package cpl_pkg;

  // Limb width of the partial-product multipliers.
  localparam int LIMB_W = 32;

  // Latency of cpl_mul in cycles.
  localparam int MUL_LAT = 3;

  localparam int CEPS_W = 17;
  localparam int DEPS_W = 32;

  typedef enum logic [0:0] {
    CFG_COMPONENT_EPS   = 1'b0,
    CFG_DENOMINATOR_EPS = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SECOND_DEG = 2'd1,
    ST_FIRST_DEG  = 2'd2,
    ST_PARALLEL   = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== sv/closest_approach_two_lines_core.sv =====
// Top level: closest-approach parameters of two 3-D lines, fully pipelined.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | 12 Q coordinates, first_start_x lowest
//  m_*      | out       | first_param, second_param; tuser = status
//  cfg_*    | in        | write enable, register index, write data
//
// One transaction enters per cycle while the output is not stalled; the
// one-bit-per-stage quotient pipelines make up most of the pipeline depth.
// Reset is synchronous, clears all valid bits and sets both thresholds to one.
// The whole pipeline advances together whenever the output stage is empty
// or its transaction is taken, so a stall holds every stage in place.
`default_nettype none

module closest_approach_two_lines_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  cpl_pkg::cfg_index_t                   cfg_index,
  input  logic [cpl_pkg::DEPS_W-1:0]            cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // first_param, second_param
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
  // status
  output logic [1:0]                            m_tuser
);
  import cpl_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 2;
  localparam int AW   = PW;
  localparam int XW   = 2 * AW;
  localparam int TW   = XW + 2;
  localparam int MGW  = XW + 1;
  localparam int NUMW = MGW + FB;
  localparam int THW  = DEPS_W + 2 * FB;
  localparam int CMPW = (MGW > THW) ? MGW : THW;
  localparam int OUTW = ((2*CW+7)/8)*8;
  localparam int LAST = 12 + CW + 3;

  // Operand pairs for the dot products a, b, c, d, e (0 = u, 1 = v, 2 = w).
  localparam int OPA [5] = '{0, 1, 1, 2, 2};
  localparam int OPB [5] = '{0, 0, 1, 1, 0};
  // Operand pairs for ac, bb, db, ec, da, be.
  localparam int M2A [6] = '{0, 1, 3, 4, 3, 1};
  localparam int M2B [6] = '{2, 1, 1, 2, 0, 4};

  logic [CEPS_W-1:0] ceps;
  logic [DEPS_W-1:0] deps;

  logic    en;
  logic    vld [1:LAST];
  status_t st  [2:LAST];

  logic signed [CW-1:0] pt [12];
  logic signed [DW-1:0] dif [3][3];
  logic [DW-1:0]        am  [3][3];
  logic [DW-1:0]        mg  [3][3];
  logic                 sg  [3][3];
  logic                 small_v;
  logic                 small_u;

  logic [DW-1:0]  m1a [15];
  logic [DW-1:0]  m1b [15];
  logic [PW-1:0]  m1p [15];
  logic [14:0]    m1s_in;
  logic [14:0]    m1s [MUL_LAT];

  logic [SW-1:0]  dot_c [5];
  logic [SW-1:0]  dot [5];
  logic [AW-1:0]  dm  [5];
  logic           dsg [5];

  logic [5:0]     m2s_in;
  logic [5:0]     m2s [MUL_LAT];
  logic [XW-1:0]  m2p [6];
  logic [TW-1:0]  t2  [6];

  logic [TW-1:0]  den;
  logic [TW-1:0]  top1;
  logic [TW-1:0]  top2;
  logic [MGW-1:0] den_m;
  logic [MGW-1:0] top1_m;
  logic [MGW-1:0] top2_m;
  logic           neg1;
  logic           neg2;
  logic           par;
  logic [CW-1:0]  q1;
  logic [CW-1:0]  q2;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ceps <= CEPS_W'(1);
      deps <= DEPS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMPONENT_EPS:   ceps <= cfg_wdata[CEPS_W-1:0];
        CFG_DENOMINATOR_EPS: deps <= cfg_wdata;
        default:             ceps <= ceps;
      endcase
    end
  end

  assign en       = !vld[LAST] || m_tready;
  assign s_tready = en;

  // Valid bits and status travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAST; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int k = 2; k <= LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (small_v) begin
        st[2] <= ST_SECOND_DEG;
      end else if (small_u) begin
        st[2] <= ST_FIRST_DEG;
      end else begin
        st[2] <= ST_OK;
      end
      for (int k = 3; k <= LAST; k++) begin
        if (k != 12) begin
          st[k] <= st[k-1];
        end
      end
      st[12] <= (st[11] == ST_OK && par) ? ST_PARALLEL : st[11];
    end
  end

  // Stage 1: u = first_end - first_start, v = second_end - second_start,
  // w = first_start - second_start.
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      pt[k] = s_tdata[k*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dif[0][i] <= DW'(pt[3+i]) - DW'(pt[i]);
        dif[1][i] <= DW'(pt[9+i]) - DW'(pt[6+i]);
        dif[2][i] <= DW'(pt[i])   - DW'(pt[6+i]);
      end
    end
  end

  // Stage 2: magnitudes, signs and the degenerate-segment tests.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        am[j][i] = dif[j][i][DW-1] ? DW'(-dif[j][i]) : DW'(dif[j][i]);
      end
    end
    small_u = 1'b1;
    small_v = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (am[0][i] >= DW'(ceps)) small_u = 1'b0;
      if (am[1][i] >= DW'(ceps)) small_v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          mg[j][i] <= am[j][i];
          sg[j][i] <= dif[j][i][DW-1];
        end
      end
    end
  end

  // Stages 3 to 5: the fifteen component products.
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      for (int i = 0; i < 3; i++) begin
        m1a[3*j+i]    = mg[OPA[j]][i];
        m1b[3*j+i]    = mg[OPB[j]][i];
        m1s_in[3*j+i] = sg[OPA[j]][i] ^ sg[OPB[j]][i];
      end
    end
  end

  for (genvar k = 0; k < 15; k++) begin : g_mul1
    cpl_mul #(.W(DW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (m1a[k]),
      .b   (m1b[k]),
      .p   (m1p[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1s[0] <= m1s_in;
      for (int k = 1; k < MUL_LAT; k++) begin
        m1s[k] <= m1s[k-1];
      end
    end
  end

  // Stage 6: signed dot products a, b, c, d, e.
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      dot_c[j] = '0;
      for (int i = 0; i < 3; i++) begin
        if (m1s[MUL_LAT-1][3*j+i]) begin
          dot_c[j] = dot_c[j] - SW'(m1p[3*j+i]);
        end else begin
          dot_c[j] = dot_c[j] + SW'(m1p[3*j+i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot <= dot_c;
    end
  end

  // Stage 7: magnitudes of the dot products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 5; j++) begin
        dm[j]  <= dot[j][SW-1] ? AW'(-dot[j]) : AW'(dot[j]);
        dsg[j] <= dot[j][SW-1];
      end
    end
  end

  // Stages 8 to 10: products ac, bb, db, ec, da, be.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      m2s_in[k] = dsg[M2A[k]] ^ dsg[M2B[k]];
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_mul2
    cpl_mul #(.W(AW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (dm[M2A[k]]),
      .b   (dm[M2B[k]]),
      .p   (m2p[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2s[0] <= m2s_in;
      for (int k = 1; k < MUL_LAT; k++) begin
        m2s[k] <= m2s[k-1];
      end
    end
  end

  // Stage 11: determinant and both numerators.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      t2[k] = m2s[MUL_LAT-1][k] ? TW'(-TW'(m2p[k])) : TW'(m2p[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den  <= t2[0] - t2[1];
      top1 <= t2[2] - t2[3];
      top2 <= t2[4] - t2[5];
    end
  end

  // Stage 12: magnitudes, quotient signs and the parallel test.
  always_comb begin
    par = (den == '0) ||
          (CMPW'(den[TW-1] ? MGW'(-den) : MGW'(den)) < (CMPW'(deps) << (2 * FB)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_m  <= den[TW-1]  ? MGW'(-den)  : MGW'(den);
      top1_m <= top1[TW-1] ? MGW'(-top1) : MGW'(top1);
      top2_m <= top2[TW-1] ? MGW'(-top2) : MGW'(top2);
      neg1   <= top1[TW-1] ^ den[TW-1];
      neg2   <= top2[TW-1] ^ den[TW-1];
    end
  end

  cpl_div #(.NUMW(NUMW), .DENW(MGW), .QW(CW)) u_div1 (
    .clk  (clk),
    .en   (en),
    .num  (NUMW'(top1_m) << FB),
    .den  (den_m),
    .neg  (neg1),
    .kill (st[12] != ST_OK),
    .quot (q1)
  );

  cpl_div #(.NUMW(NUMW), .DENW(MGW), .QW(CW)) u_div2 (
    .clk  (clk),
    .en   (en),
    .num  (NUMW'(top2_m) << FB),
    .den  (den_m),
    .neg  (neg2),
    .kill (st[12] != ST_OK),
    .quot (q2)
  );

  assign m_tvalid = vld[LAST];
  assign m_tdata  = OUTW'({q2, q1});
  assign m_tuser  = st[LAST];

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (q1 == '0) && (q2 == '0))
    else $error("nonzero parameters on a failed transaction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_ready_follow: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stage");

  a_ceps_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == CFG_COMPONENT_EPS) |=> ceps == $past(cfg_wdata[CEPS_W-1:0]))
    else $error("component threshold write lost");
`endif

endmodule

`default_nettype wire

// ===== sv/cpl_mul.sv =====
// Pipelined unsigned multiplier built from limb partial products.
`default_nettype none

module cpl_mul #(
  parameter int W = 33
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);
  import cpl_pkg::*;

  localparam int L  = LIMB_W;
  localparam int N  = (W + L - 1) / L;
  localparam int EW = N * L;
  localparam int RW = (N + 1) * L;

  logic [EW-1:0]    ax;
  logic [EW-1:0]    bx;
  logic [2*L-1:0]   pp [N][N];
  logic [RW-1:0]    row_sum [N];
  logic [RW-1:0]    row [N];
  logic [2*EW-1:0]  total;

  assign ax = EW'(a);
  assign bx = EW'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          pp[i][j] <= ax[i*L +: L] * bx[j*L +: L];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < N; j++) begin
        row_sum[i] = row_sum[i] + (RW'(pp[i][j]) << (L * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        row[i] <= row_sum[i];
      end
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < N; i++) begin
      total = total + ((2*EW)'(row[i]) << (L * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= total[2*W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cpl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
`default_nettype none

module cpl_div #(
  parameter int NUMW = 149,
  parameter int DENW = 133,
  parameter int QW   = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  input  logic            neg,
  input  logic            kill,
  output logic [QW-1:0]   quot
);
  import cpl_pkg::*;

  localparam int RW = ((NUMW > DENW + QW) ? NUMW : (DENW + QW)) + 1;
  localparam logic [QW:0] LIM_POS = (QW+1)'((64'd1 << (QW - 1)) - 64'd1);
  localparam logic [QW:0] LIM_NEG = (QW+1)'(64'd1 << (QW - 1));

  logic [RW-1:0]   rem [QW+1];
  logic [DENW-1:0] dr  [QW+1];
  logic [QW-1:0]   q   [QW+1];
  logic            ng  [QW+1];
  logic            kl  [QW+1];
  logic            ov  [QW+1];

  logic [QW:0] qr;
  logic        ng_r;
  logic        kl_r;
  logic        ov_r;
  logic [QW:0] lim;
  logic [QW:0] sat;

  // Stage 0 checks whether the quotient needs more than QW bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num);
      dr[0]  <= den;
      q[0]   <= '0;
      ng[0]  <= neg;
      kl[0]  <= kill;
      ov[0]  <= RW'(num) >= (RW'(den) << QW);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s <= QW; s++) begin
        if (rem[s-1] >= (RW'(dr[s-1]) << (QW - s))) begin
          rem[s] <= rem[s-1] - (RW'(dr[s-1]) << (QW - s));
          q[s]   <= q[s-1] | (QW'(1) << (QW - s));
        end else begin
          rem[s] <= rem[s-1];
          q[s]   <= q[s-1];
        end
        dr[s] <= dr[s-1];
        ng[s] <= ng[s-1];
        kl[s] <= kl[s-1];
        ov[s] <= ov[s-1];
      end
    end
  end

  // Round to nearest, ties away from zero, on the magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      qr   <= (QW+1)'(q[QW]) + (QW+1)'((rem[QW] << 1) >= RW'(dr[QW]));
      ng_r <= ng[QW];
      kl_r <= kl[QW];
      ov_r <= ov[QW];
    end
  end

  always_comb begin
    lim = ng_r ? LIM_NEG : LIM_POS;
    sat = (ov_r || (qr > lim)) ? lim : qr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (kl_r) begin
        quot <= '0;
      end else if (ng_r) begin
        quot <= QW'(-sat);
      end else begin
        quot <= QW'(sat);
      end
    end
  end

endmodule

`default_nettype wire
